### rtl/core/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the cardinal spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned QW        = 17;
  localparam int unsigned T2_W      = 18;
  localparam int unsigned T3_W      = 19;
  localparam int unsigned WGT_W     = 42;
  localparam int unsigned WLO_W     = 21;
  localparam int unsigned WHI_W     = WGT_W - WLO_W;
  localparam int unsigned BASIS_LAT = 4;
  localparam int unsigned MAC_LAT   = 3;
  localparam int unsigned PIPE_LAT  = BASIS_LAT + MAC_LAT;

  localparam logic [QW-1:0] TENSION_RST = 17'd32768;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef wgt_t   [3:0] wquad_t;
  typedef coord_t [3:0] cquad_t;

  localparam wgt_t   QONE_SQ   = wgt_t'(64'h1_0000_0000);
  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [QW-1:0]        param_t;
    logic signed [31:0]   p0_x;
    logic signed [31:0]   p0_y;
    logic signed [31:0]   p1_x;
    logic signed [31:0]   p1_y;
    logic signed [31:0]   p2_x;
    logic signed [31:0]   p2_y;
    logic signed [31:0]   p3_x;
    logic signed [31:0]   p3_y;
  } cse_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] bend_x;
    logic signed [31:0] bend_y;
    logic               overflow;
  } cse_out_t;

  typedef struct packed {
    wquad_t pos;
    wquad_t slope;
    wquad_t bend;
    cquad_t px;
    cquad_t py;
  } basis_t;

endpackage

`default_nettype wire

### rtl/core/cardinal_spline_evaluator_top.sv
// ----------------------------------------------------------------------------
// cardinal_spline_evaluator_top
// Cardinal spline point, slope and bend for one segment per beat.
// ----------------------------------------------------------------------------
// Fully pipelined: a beat is taken every cycle (busy stays low) and its
// result appears on res_o with done_o, one beat per cycle with no
// backpressure. The pipeline has seven register stages: four in the basis
// unit (t^2, t^3, tension products, weights) and three in each of the
// six coordinate MACs. The tension in effect when a beat is taken applies
// to it; write tension only while the pipe is empty.
`default_nettype none

module cardinal_spline_evaluator_top import cse_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cse_in_t       in_i,
  input  logic          cfg_we_i,
  input  logic [QW-1:0] cfg_wdata_i,
  output logic          done_o,
  output cse_out_t      res_o
);

  logic [QW-1:0]       tension_q;
  logic [PIPE_LAT-1:0] vld_q, vld_d;
  basis_t              basis;
  coord_t              val [6];
  logic [5:0]          sat;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= TENSION_RST;
    end else if (cfg_we_i) begin
      tension_q <= cfg_wdata_i;
    end
  end

  assign vld_d = {vld_q[PIPE_LAT-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  cse_basis u_basis (
    .clk_i     (clk_i),
    .item_i    (in_i),
    .tension_i (tension_q),
    .basis_o   (basis)
  );

  cse_mac u_mac_point_x (
    .clk_i (clk_i), .wgt_i (basis.pos), .pt_i (basis.px),
    .value_o (val[0]), .sat_o (sat[0])
  );

  cse_mac u_mac_point_y (
    .clk_i (clk_i), .wgt_i (basis.pos), .pt_i (basis.py),
    .value_o (val[1]), .sat_o (sat[1])
  );

  cse_mac u_mac_slope_x (
    .clk_i (clk_i), .wgt_i (basis.slope), .pt_i (basis.px),
    .value_o (val[2]), .sat_o (sat[2])
  );

  cse_mac u_mac_slope_y (
    .clk_i (clk_i), .wgt_i (basis.slope), .pt_i (basis.py),
    .value_o (val[3]), .sat_o (sat[3])
  );

  cse_mac u_mac_bend_x (
    .clk_i (clk_i), .wgt_i (basis.bend), .pt_i (basis.px),
    .value_o (val[4]), .sat_o (sat[4])
  );

  cse_mac u_mac_bend_y (
    .clk_i (clk_i), .wgt_i (basis.bend), .pt_i (basis.py),
    .value_o (val[5]), .sat_o (sat[5])
  );

  assign done_o = vld_q[PIPE_LAT-1];

  always_comb begin
    res_o.point_x  = val[0];
    res_o.point_y  = val[1];
    res_o.slope_x  = val[2];
    res_o.slope_y  = val[3];
    res_o.bend_x   = val[4];
    res_o.bend_y   = val[5];
    res_o.overflow = |sat;
  end

endmodule

`default_nettype wire

### rtl/core/cse_basis.sv
// ----------------------------------------------------------------------------
// cse_basis
// Four-stage pipeline: t^2, t^3 and tension products, then the twelve
// basis weights (Q.32). Control points ride along to stay aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_basis import cse_pkg::*; (
  input  logic          clk_i,
  input  cse_in_t       item_i,
  input  logic [QW-1:0] tension_i,
  output basis_t        basis_o
);

  localparam wgt_t K2  = wgt_t'(2);
  localparam wgt_t K3  = wgt_t'(3);
  localparam wgt_t K4  = wgt_t'(4);
  localparam wgt_t K6  = wgt_t'(6);
  localparam wgt_t K12 = wgt_t'(12);

  // stage A: T*T and U*T
  logic [QW-1:0]   a_t_q, a_u_q;
  logic [2*QW-1:0] a_tt_q, a_c_q;
  cquad_t          a_px_q, a_py_q;

  always_ff @(posedge clk_i) begin
    a_t_q  <= item_i.param_t;
    a_u_q  <= tension_i;
    a_tt_q <= item_i.param_t * item_i.param_t;
    a_c_q  <= tension_i * item_i.param_t;
    a_px_q <= {item_i.p3_x, item_i.p2_x, item_i.p1_x, item_i.p0_x};
    a_py_q <= {item_i.p3_y, item_i.p2_y, item_i.p1_y, item_i.p0_y};
  end

  // stage B: t2 rounded, t2*T and U*t2
  logic [2*QW:0]   tt_rnd;
  logic [T2_W-1:0] t2;
  logic [QW-1:0]   b_t_q, b_u_q;
  logic [T2_W-1:0] b_t2_q;
  logic [34:0]     b_t2t_q, b_b_q;
  logic [2*QW-1:0] b_c_q;
  cquad_t          b_px_q, b_py_q;

  assign tt_rnd = {1'b0, a_tt_q} + 35'd32768;
  assign t2     = tt_rnd[33:16];

  always_ff @(posedge clk_i) begin
    b_t_q   <= a_t_q;
    b_u_q   <= a_u_q;
    b_t2_q  <= t2;
    b_t2t_q <= t2 * a_t_q;
    b_b_q   <= a_u_q * t2;
    b_c_q   <= a_c_q;
    b_px_q  <= a_px_q;
    b_py_q  <= a_py_q;
  end

  // stage C: t3 rounded and U*t3
  logic [35:0]     t2t_rnd;
  logic [T3_W-1:0] t3;
  logic [QW-1:0]   c_t_q, c_u_q;
  logic [T2_W-1:0] c_t2_q;
  logic [T3_W-1:0] c_t3_q;
  logic [35:0]     c_a_q;
  logic [34:0]     c_b_q;
  logic [2*QW-1:0] c_c_q;
  cquad_t          c_px_q, c_py_q;

  assign t2t_rnd = {1'b0, b_t2t_q} + 36'd32768;
  assign t3      = t2t_rnd[34:16];

  always_ff @(posedge clk_i) begin
    c_t_q  <= b_t_q;
    c_u_q  <= b_u_q;
    c_t2_q <= b_t2_q;
    c_t3_q <= t3;
    c_a_q  <= b_u_q * t3;
    c_b_q  <= b_b_q;
    c_c_q  <= b_c_q;
    c_px_q <= b_px_q;
    c_py_q <= b_py_q;
  end

  // stage D: weights
  wgt_t   ut3, ut2, ut, s_t3, s_t2, s_t, s_u;
  wquad_t pos_d, slope_d, bend_d;
  wquad_t d_pos_q, d_slope_q, d_bend_q;
  cquad_t d_px_q, d_py_q;

  assign ut3  = $signed({6'd0, c_a_q});
  assign ut2  = $signed({7'd0, c_b_q});
  assign ut   = $signed({8'd0, c_c_q});
  assign s_t3 = $signed({7'd0, c_t3_q, 16'd0});
  assign s_t2 = $signed({8'd0, c_t2_q, 16'd0});
  assign s_t  = $signed({9'd0, c_t_q, 16'd0});
  assign s_u  = $signed({9'd0, c_u_q, 16'd0});

  always_comb begin
    pos_d[0]   = -ut3 + K2 * ut2 - ut;
    pos_d[1]   = K2 * s_t3 - ut3 + ut2 - K3 * s_t2 + QONE_SQ;
    pos_d[2]   = ut3 - K2 * s_t3 + K3 * s_t2 - K2 * ut2 + ut;
    pos_d[3]   = ut3 - ut2;
    slope_d[0] = -(K3 * ut2) + K4 * ut - s_u;
    slope_d[1] = K2 * ut - K6 * s_t - K3 * ut2 + K6 * s_t2;
    slope_d[2] = s_u - K4 * ut + K6 * s_t + K3 * ut2 - K6 * s_t2;
    slope_d[3] = K3 * ut2 - K2 * ut;
    bend_d[0]  = K4 * s_u - K6 * ut;
    bend_d[1]  = -(K6 * ut) + K12 * s_t + K2 * s_u - K6 * QONE_SQ;
    bend_d[2]  = K6 * ut - K12 * s_t - K4 * s_u + K6 * QONE_SQ;
    bend_d[3]  = K6 * ut - K2 * s_u;
  end

  always_ff @(posedge clk_i) begin
    d_pos_q   <= pos_d;
    d_slope_q <= slope_d;
    d_bend_q  <= bend_d;
    d_px_q    <= c_px_q;
    d_py_q    <= c_py_q;
  end

  assign basis_o = '{pos: d_pos_q, slope: d_slope_q, bend: d_bend_q,
                     px: d_px_q, py: d_py_q};

endmodule

`default_nettype wire

### rtl/core/cse_mac.sv
// ----------------------------------------------------------------------------
// cse_mac
// Three-stage weighted sum of four control coordinates: split-weight
// products, partial sums, then rounding, scaling by 2^-32 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_mac import cse_pkg::*; (
  input  logic   clk_i,
  input  wquad_t wgt_i,
  input  cquad_t pt_i,
  output coord_t value_o,
  output logic   sat_o
);

  localparam int unsigned PLO_W = WLO_W + 1 + COORD_W;
  localparam int unsigned PHI_W = WHI_W + COORD_W;
  localparam int unsigned SLO_W = PLO_W + 2;
  localparam int unsigned SHI_W = PHI_W + 2;
  localparam int unsigned TOT_W = SHI_W + WLO_W + 2;
  localparam int unsigned RES_W = TOT_W - 32;

  localparam logic signed [TOT_W-1:0] RND_HALF = TOT_W'(64'h8000_0000);

  // stage E: weight split into unsigned low and signed high halves
  logic signed [PLO_W-1:0] plo_q [4];
  logic signed [PHI_W-1:0] phi_q [4];

  for (genvar i = 0; i < 4; i++) begin : g_prod
    always_ff @(posedge clk_i) begin
      plo_q[i] <= $signed({1'b0, wgt_i[i][WLO_W-1:0]}) * pt_i[i];
      phi_q[i] <= $signed(wgt_i[i][WGT_W-1:WLO_W]) * pt_i[i];
    end
  end

  // stage F
  logic signed [SLO_W-1:0] slo_q;
  logic signed [SHI_W-1:0] shi_q;

  always_ff @(posedge clk_i) begin
    slo_q <= SLO_W'(plo_q[0]) + SLO_W'(plo_q[1]) + SLO_W'(plo_q[2]) + SLO_W'(plo_q[3]);
    shi_q <= SHI_W'(phi_q[0]) + SHI_W'(phi_q[1]) + SHI_W'(phi_q[2]) + SHI_W'(phi_q[3]);
  end

  // stage G
  logic signed [TOT_W-1:0] total;
  logic signed [RES_W-1:0] scaled;
  logic                    in_range;
  coord_t                  value_d;
  coord_t                  value_q;
  logic                    sat_q;

  assign total    = (TOT_W'(shi_q) <<< WLO_W) + TOT_W'(slo_q) + RND_HALF;
  assign scaled   = total[TOT_W-1:32];
  assign in_range = (&scaled[RES_W-1:COORD_W-1]) | ~(|scaled[RES_W-1:COORD_W-1]);

  always_comb begin
    if (in_range) begin
      value_d = scaled[COORD_W-1:0];
    end else if (scaled[RES_W-1]) begin
      value_d = COORD_MIN;
    end else begin
      value_d = COORD_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    sat_q   <= ~in_range;
  end

  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

### rtl/core/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks of the spline evaluator: fixed latency, no stray
// results, and overflow only with a saturated value.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_checker import cse_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done_o,
  input wire cse_out_t res_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT done_o)
    else $error("result beat missing after accepted item");

  a_no_stray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without matching item");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |->
      (res_o.point_x == COORD_MAX || res_o.point_x == COORD_MIN ||
       res_o.point_y == COORD_MAX || res_o.point_y == COORD_MIN ||
       res_o.slope_x == COORD_MAX || res_o.slope_x == COORD_MIN ||
       res_o.slope_y == COORD_MAX || res_o.slope_y == COORD_MIN ||
       res_o.bend_x  == COORD_MAX || res_o.bend_x  == COORD_MIN ||
       res_o.bend_y  == COORD_MAX || res_o.bend_y  == COORD_MIN))
    else $error("overflow flagged without a saturated value");

endmodule

bind cardinal_spline_evaluator_top cse_checker u_cse_checker (.*);

`default_nettype wire
